// File: rtl/ppu_pkg.sv
// Shared types, constants and helpers for the particle pool update core.
// No dependencies.
`default_nettype none
package ppu_pkg;

  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned POOL_AW    = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W      = POOL_AW + 1;
  localparam int unsigned SLOT_W     = 192;   // px, py, vx, vy, life, rot

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_EMIT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_DAMPING  = 3'd1;
  localparam logic [2:0] REG_JITTER_X = 3'd2;
  localparam logic [2:0] REG_JITTER_Y = 3'd3;
  localparam logic [2:0] REG_POOL     = 3'd4;

  localparam logic [31:0] LFSR_MASK = 32'hD000_0001;
  localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;

  // floor(ts / 100) == (ts * ROT_RECIP) >> 24 for every 16-bit ts
  localparam logic [33:0] ROT_RECIP = 34'd167773;

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  function automatic logic [31:0] sat36(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/particle_pool_update_core.sv
// Particle pool update core: sequencer, active flags, config registers.
// Depends on ppu_pkg, ppu_ram, ppu_mul.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | sink      | in_valid_i/in_stall_o | command .. lifetime
//  out     | source    | out_valid_o/out_stall_i | slot_index .. angle
//  cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// Tick: setup, then a scan that skips idle slots, clears expiring slots and
// updates living slots below the configured pool size, then finish; the single
// multiplier sets the pace.
// Reset clears flags and control; slot RAM contents are undefined until emit.
// in_stall_o is high while an item is in work; a held result does not block
// the next item, only the final hand-off to the output register.
`default_nettype none
module particle_pool_update_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [7:0]         slot_select_i,
  input  wire logic [15:0]        time_step_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] speed_x_i,
  input  wire logic signed [31:0] speed_y_i,
  input  wire logic [30:0]        lifetime_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         slot_index_o,
  output      logic               live_o,
  output      logic [8:0]         live_count_o,
  output      logic signed [31:0] place_x_o,
  output      logic signed [31:0] place_y_o,
  output      logic signed [31:0] motion_x_o,
  output      logic signed [31:0] motion_y_o,
  output      logic signed [31:0] life_left_o,
  output      logic signed [31:0] angle_o
);
  import ppu_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TPRE  = 5'd1;
  localparam logic [4:0] S_TF    = 5'd2;
  localparam logic [4:0] S_TSCAN = 5'd3;
  localparam logic [4:0] S_TLOAD = 5'd4;
  localparam logic [4:0] S_MVX   = 5'd5;
  localparam logic [4:0] S_MVY   = 5'd6;
  localparam logic [4:0] S_MPX   = 5'd7;
  localparam logic [4:0] S_MPY   = 5'd8;
  localparam logic [4:0] S_TFIN  = 5'd9;
  localparam logic [4:0] S_TWR   = 5'd10;
  localparam logic [4:0] S_EROT  = 5'd11;
  localparam logic [4:0] S_EJX   = 5'd12;
  localparam logic [4:0] S_EJY   = 5'd13;
  localparam logic [4:0] S_EFIN  = 5'd14;
  localparam logic [4:0] S_EWR   = 5'd15;
  localparam logic [4:0] S_RDATA = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  // config
  logic        gravity_q;
  logic [15:0] damping_q;
  logic [30:0] jitter_x_q, jitter_y_q;
  logic [CNT_W-1:0] pool_q;
  logic [POOL_AW-1:0] ptr_q;
  logic [31:0] lfsr_q;
  logic [POOL_DEPTH-1:0] flag_q;

  logic [4:0] state_q;

  // latched item
  logic [1:0]  cmd_q;
  logic [7:0]  sel_q;
  logic [15:0] ts_q;
  logic [31:0] sx_q, sy_q, vx_in_q, vy_in_q;
  logic [30:0] life_in_q;

  // work registers
  logic [31:0] px_q, py_q, vx_q, vy_q, life_q, rot_q;
  logic [16:0] f_q;
  logic [9:0]  rot_inc_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] count_q;
  logic [POOL_AW-1:0] slot_q;
  logic        live_q;
  logic        ok_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic signed [34:0] prod_sh;

  ppu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_sh = prod[50:16];

  logic [31:0] lfsr_nx;
  logic [15:0] rnd;
  logic signed [17:0] rnd_c;
  assign lfsr_nx = lfsr_step(lfsr_q);
  assign rnd     = lfsr_nx[31:16];
  assign rnd_c   = $signed({2'b00, rnd}) - 18'sd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TPRE: begin
        mul_a = $signed({17'd0, damping_q});
        mul_b = $signed({2'b00, ts_q});
      end
      S_MVX: begin
        mul_a = $signed({vx_q[31], vx_q});
        mul_b = $signed({1'b0, f_q});
      end
      S_MVY: begin
        mul_a = $signed({vy_q[31], vy_q});
        mul_b = $signed({1'b0, f_q});
      end
      S_MPX: begin
        mul_a = $signed({vx_q[31], vx_q});
        mul_b = $signed({2'b00, ts_q});
      end
      S_MPY: begin
        mul_a = $signed({vy_q[31], vy_q});
        mul_b = $signed({2'b00, ts_q});
      end
      S_EJX: begin
        mul_a = $signed({2'b00, jitter_x_q});
        mul_b = rnd_c;
      end
      S_EJY: begin
        mul_a = $signed({2'b00, jitter_y_q});
        mul_b = rnd_c;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // slot RAM
  logic [POOL_AW-1:0] raddr;
  logic [SLOT_W-1:0]  rdata, wdata;
  logic               ram_we;
  logic [31:0]        rot_wr;
  logic signed [35:0] rot_sum;

  assign raddr   = (state_q == S_IDLE) ? slot_select_i : idx_q[POOL_AW-1:0];
  assign rot_sum = $signed({{4{rot_q[31]}}, rot_q}) + $signed({26'd0, rot_inc_q});
  assign rot_wr  = (state_q == S_TWR) ? sat36(rot_sum) : rot_q;
  assign wdata   = {px_q, py_q, vx_q, vy_q, life_q, rot_wr};
  assign ram_we  = (state_q == S_TWR) || (state_q == S_EWR);

  ppu_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ((state_q == S_TWR) ? idx_q[POOL_AW-1:0] : slot_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [31:0] rd_px, rd_py, rd_vx, rd_vy, rd_life, rd_rot;
  assign {rd_px, rd_py, rd_vx, rd_vy, rd_life, rd_rot} = rdata;

  // clamped config value for pool size
  logic [CNT_W-1:0] pool_wr;
  always_comb begin
    pool_wr = cfg_data_i[CNT_W-1:0];
    if (pool_wr == '0) begin
      pool_wr = CNT_W'(1);
    end else if (pool_wr > CNT_W'(POOL_DEPTH)) begin
      pool_wr = CNT_W'(POOL_DEPTH);
    end
  end

  logic in_acc, out_free;
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;

  logic [CNT_W-1:0] pool_m1;
  assign pool_m1 = pool_q - CNT_W'(1);

  logic [33:0] ri_prod;
  assign ri_prod = {18'd0, ts_q} * ROT_RECIP;

  logic signed [35:0] ts_s, ts10_s;
  assign ts_s   = $signed({20'd0, ts_q});
  assign ts10_s = $signed({16'd0, ({4'd0, ts_q} << 3) + ({4'd0, ts_q} << 1)});

  function automatic logic signed [35:0] sx36(input logic [31:0] v);
    return $signed({{4{v[31]}}, v});
  endfunction

  // control and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      gravity_q  <= 1'b1;
      damping_q  <= '0;
      jitter_x_q <= '0;
      jitter_y_q <= '0;
      pool_q     <= CNT_W'(POOL_DEPTH);
      ptr_q      <= POOL_AW'(POOL_DEPTH - 1);
      lfsr_q     <= LFSR_SEED;
      flag_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRAVITY:  gravity_q  <= cfg_data_i[0];
          REG_DAMPING:  damping_q  <= cfg_data_i[15:0];
          REG_JITTER_X: jitter_x_q <= cfg_data_i;
          REG_JITTER_Y: jitter_y_q <= cfg_data_i;
          REG_POOL: begin
            pool_q <= pool_wr;
            ptr_q  <= POOL_AW'(pool_wr - CNT_W'(1));
            for (int i = 0; i < POOL_DEPTH; i++) begin
              if (CNT_W'(i) >= pool_wr) begin
                flag_q[i] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      // new result wins over the hand-off of the old one
      if (state_q == S_DONE && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (command_i)
              CMD_TICK: state_q <= S_TPRE;
              CMD_EMIT: state_q <= S_EROT;
              CMD_READ: begin
                state_q <= ({1'b0, slot_select_i} < pool_q) ? S_RDATA : S_DONE;
              end
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_TPRE:  state_q <= S_TF;
        S_TF:    state_q <= S_TSCAN;
        S_TSCAN: begin
          if (idx_q >= pool_q) begin
            state_q <= S_DONE;
          end else if (flag_q[idx_q[POOL_AW-1:0]]) begin
            state_q <= S_TLOAD;
          end
        end
        S_TLOAD: begin
          if ($signed(rd_life) <= 32'sd0) begin
            flag_q[idx_q[POOL_AW-1:0]] <= 1'b0;
            state_q <= S_TSCAN;
          end else begin
            state_q <= S_MVX;
          end
        end
        S_MVX:  state_q <= S_MVY;
        S_MVY:  state_q <= S_MPX;
        S_MPX:  state_q <= S_MPY;
        S_MPY:  state_q <= S_TFIN;
        S_TFIN: state_q <= S_TWR;
        S_TWR:  state_q <= S_TSCAN;
        S_EROT: begin
          lfsr_q  <= lfsr_nx;
          state_q <= S_EJX;
        end
        S_EJX: begin
          lfsr_q  <= lfsr_nx;
          state_q <= S_EJY;
        end
        S_EJY: begin
          lfsr_q  <= lfsr_nx;
          state_q <= S_EFIN;
        end
        S_EFIN: state_q <= S_EWR;
        S_EWR: begin
          flag_q[slot_q] <= 1'b1;
          ptr_q   <= (slot_q == '0) ? pool_m1[POOL_AW-1:0] : slot_q - POOL_AW'(1);
          state_q <= S_DONE;
        end
        S_RDATA: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q     <= command_i;
          sel_q     <= slot_select_i;
          ts_q      <= time_step_i;
          sx_q      <= start_x_i;
          sy_q      <= start_y_i;
          vx_in_q   <= speed_x_i;
          vy_in_q   <= speed_y_i;
          life_in_q <= lifetime_i;
          idx_q     <= '0;
          count_q   <= '0;
          ok_q      <= ({1'b0, slot_select_i} < pool_q);
          slot_q    <= ({1'b0, ptr_q} >= pool_q) ? pool_m1[POOL_AW-1:0] : ptr_q;
        end
      end
      S_TPRE: rot_inc_q <= ri_prod[33:24];
      S_TF:   f_q <= 17'h10000 - {1'b0, prod[31:16]};
      S_TSCAN: begin
        if (idx_q < pool_q && !flag_q[idx_q[POOL_AW-1:0]]) begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      S_TLOAD: begin
        if ($signed(rd_life) <= 32'sd0) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        px_q   <= rd_px;
        py_q   <= rd_py;
        vx_q   <= rd_vx;
        vy_q   <= gravity_q ? sat36(sx36(rd_vy) - ts10_s) : rd_vy;
        life_q <= sat36(sx36(rd_life) - ts_s);
        rot_q  <= rd_rot;
      end
      S_MVY:  vx_q <= sat36(36'(prod_sh));
      S_MPX:  vy_q <= sat36(36'(prod_sh));
      S_MPY:  px_q <= sat36(sx36(px_q) + 36'(prod_sh));
      S_TFIN: py_q <= sat36(sx36(py_q) + 36'(prod_sh));
      S_TWR: begin
        idx_q   <= idx_q + CNT_W'(1);
        count_q <= count_q + CNT_W'(1);
      end
      S_EROT: begin
        rot_q  <= {7'd0, {9'd0, rnd} * 25'd360};
        px_q   <= sx_q;
        py_q   <= sy_q;
        life_q <= {1'b0, life_in_q};
      end
      S_EJY:  vx_q <= sat36(sx36(vx_in_q) + 36'(prod_sh));
      S_EFIN: vy_q <= sat36(sx36(vy_in_q) + 36'(prod_sh));
      S_RDATA: begin
        px_q   <= rd_px;
        py_q   <= rd_py;
        vx_q   <= rd_vx;
        vy_q   <= rd_vy;
        life_q <= rd_life;
        rot_q  <= rd_rot;
        live_q <= flag_q[sel_q];
      end
      default: ;
    endcase
  end

  // result register
  logic is_rd, is_em, is_tk;
  assign is_rd = (cmd_q == CMD_READ);
  assign is_em = (cmd_q == CMD_EMIT);
  assign is_tk = (cmd_q == CMD_TICK);

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      slot_index_o <= is_rd ? sel_q : (is_em ? slot_q : 8'd0);
      live_o       <= is_em || (is_rd && ok_q && live_q);
      live_count_o <= is_tk ? count_q : 9'd0;
      place_x_o    <= (is_rd && ok_q) ? px_q : 32'd0;
      place_y_o    <= (is_rd && ok_q) ? py_q : 32'd0;
      motion_x_o   <= (is_rd && ok_q) ? vx_q : 32'd0;
      motion_y_o   <= (is_rd && ok_q) ? vy_q : 32'd0;
      life_left_o  <= (is_rd && ok_q) ? life_q : 32'd0;
      angle_o      <= (is_rd && ok_q) ? rot_q : 32'd0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ppu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/ppu_mul.sv
// Shared signed 33x18 multiplier with registered product.
// Depends on nothing but its operands.
`default_nettype none
module ppu_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [17:0] b_i,
  output      logic signed [50:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule
`default_nettype wire
